[src/mdq_pkg.sv]
package mdq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 1024;

  localparam int SPAN_W      = 24;
  localparam int SERVICE_W   = 24;
  localparam int LIMIT_W     = 11;
  localparam int FIRST_W     = 24;
  localparam int SAMPLE_W    = 16;
  localparam int GAP_W       = 25;
  localparam int TOTAL_W     = 64;
  localparam int OCC_W       = 11;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 3;

  localparam logic [SPAN_W-1:0]    SPAN_RESET     = SPAN_W'(1000);
  localparam logic [SERVICE_W-1:0] SERVICE_RESET  = SERVICE_W'(1000);
  localparam logic [LIMIT_W-1:0]   LIMIT_RESET    = LIMIT_W'(1024);
  localparam logic                 BOUNDED_RESET  = 1'b0;
  localparam logic [FIRST_W-1:0]   FIRST_RESET    = FIRST_W'(1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SPAN    = 3'd0,
    CFG_SERVICE = 3'd1,
    CFG_LIMIT   = 3'd2,
    CFG_BOUNDED = 3'd3,
    CFG_FIRST   = 3'd4
  } cfg_index_t;

  // One tick as it leaves the input register: the arrival gap is already formed.
  typedef struct packed {
    logic [GAP_W-1:0] gap;
    logic             last;
  } tick_item_t;

endpackage

[src/mdq_in_stage.sv]
module mdq_in_stage
  import mdq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                last,
  input  logic [SPAN_W-1:0]   span,
  output logic                item_valid,
  output tick_item_t          item
);

  logic [SPAN_W+SAMPLE_W-1:0] product;
  logic [GAP_W-1:0]           gap_next;

  // Gap to the following arrival: floor(span * u / 65536) + 1.
  assign product  = span * sample;
  assign gap_next = GAP_W'(product[SPAN_W+SAMPLE_W-1:SAMPLE_W]) + GAP_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.gap  <= gap_next;
      item.last <= last;
    end
  end

endmodule

[src/mdq_ts_mem.sv]
module mdq_ts_mem
  import mdq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
  localparam int AW = $clog2(QUEUE_DEPTH)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [TOTAL_W-1:0] wr_data,
  input  logic [AW-1:0]      rd_addr,
  output logic [TOTAL_W-1:0] rd_value
);

  logic [TOTAL_W-1:0] mem [QUEUE_DEPTH];
  logic [TOTAL_W-1:0] rd_data;
  logic [TOTAL_W-1:0] fwd_data;
  logic               fwd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read-before-write memory; a write to the address being read is forwarded.
  always_ff @(posedge clk) begin
    rd_data  <= mem[rd_addr];
    fwd      <= wr_en && (wr_addr == rd_addr);
    fwd_data <= wr_data;
  end

  assign rd_value = fwd ? fwd_data : rd_data;

endmodule

[src/mdq_core.sv]
module mdq_core
  import mdq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
  localparam int AW = $clog2(QUEUE_DEPTH),
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  tick_item_t           item,
  input  logic [SERVICE_W-1:0] service_ticks,
  input  logic [LIMIT_W-1:0]   queue_limit,
  input  logic                 bounded_mode,
  input  logic [FIRST_W-1:0]   first_arrival,
  input  logic                 first_wr,
  output logic                 mem_wr_en,
  output logic [AW-1:0]        mem_wr_addr,
  output logic [TOTAL_W-1:0]   mem_wr_data,
  output logic [AW-1:0]        mem_rd_addr,
  input  logic [TOTAL_W-1:0]   next_entry,
  output logic                 done,
  output logic [OCC_W-1:0]     queue_occupancy,
  output logic [TOTAL_W-1:0]   packets_arrived,
  output logic [TOTAL_W-1:0]   packets_lost,
  output logic [TOTAL_W-1:0]   idle_checks,
  output logic [TOTAL_W-1:0]   queue_delay_sum,
  output logic [TOTAL_W-1:0]   sojourn_sum,
  output logic [TOTAL_W-1:0]   occupancy_sum,
  output logic                 final_flag
);

  localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;

  logic [TOTAL_W-1:0]   tick_count, tick_count_next;
  logic [TOTAL_W-1:0]   next_arrival, next_arrival_next;
  logic [TOTAL_W-1:0]   next_check, next_check_next;
  logic [SERVICE_W-1:0] remaining, remaining_next;
  logic [AW-1:0]        head, head_next;
  logic [AW-1:0]        tail, tail_next;
  logic [CW-1:0]        count, count_next;
  logic [TOTAL_W-1:0]   head_ts, head_ts_next;
  logic [TOTAL_W-1:0]   arrival_total, arrival_total_next;
  logic [TOTAL_W-1:0]   loss_total, loss_total_next;
  logic [TOTAL_W-1:0]   idle_total, idle_total_next;
  logic [TOTAL_W-1:0]   delay_total, delay_total_next;
  logic [TOTAL_W-1:0]   sojourn_total, sojourn_total_next;
  logic [TOTAL_W-1:0]   occupancy_total, occupancy_total_next;

  logic [TOTAL_W-1:0]   t;
  logic [TOTAL_W-1:0]   head_val;
  logic [TOTAL_W-1:0]   wait_time;
  logic [SERVICE_W-1:0] slen;
  logic [SERVICE_W-1:0] rem_loaded;
  logic [CMPW-1:0]      capacity;
  logic [CW-1:0]        count_pushed;
  logic                 arrive, full, push, check, start_svc, counting, pop;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
    ring_next = (idx == AW'(QUEUE_DEPTH - 1)) ? '0 : idx + AW'(1);
  endfunction

  always_comb begin
    t        = tick_count + TOTAL_W'(1);
    slen     = (service_ticks == '0) ? SERVICE_W'(1) : service_ticks;
    capacity = (bounded_mode && (CMPW'(queue_limit) < CMPW'(QUEUE_DEPTH))) ?
               CMPW'(queue_limit) : CMPW'(QUEUE_DEPTH);

    arrive       = (t == next_arrival);
    full         = (CMPW'(count) >= capacity);
    push         = arrive && !full;
    count_pushed = count + CW'(push);

    // A packet pushed into an empty queue becomes the head in the same tick.
    head_val  = (count == '0) ? t : head_ts;
    wait_time = t - head_val;

    check      = (t == next_check);
    start_svc  = check && (count_pushed != '0);
    rem_loaded = check ? (start_svc ? slen : '0) : remaining;
    counting   = (rem_loaded != '0);
    pop        = counting && (rem_loaded == SERVICE_W'(1)) && (count_pushed != '0);
  end

  always_comb begin
    tick_count_next      = tick_count;
    next_arrival_next    = next_arrival;
    next_check_next      = next_check;
    remaining_next       = remaining;
    head_next            = head;
    tail_next            = tail;
    count_next           = count;
    head_ts_next         = head_ts;
    arrival_total_next   = arrival_total;
    loss_total_next      = loss_total;
    idle_total_next      = idle_total;
    delay_total_next     = delay_total;
    sojourn_total_next   = sojourn_total;
    occupancy_total_next = occupancy_total;

    if (item_valid) begin
      tick_count_next = t;
      if (arrive) begin
        arrival_total_next = arrival_total + TOTAL_W'(1);
        next_arrival_next  = next_arrival + TOTAL_W'(item.gap);
        if (full) begin
          loss_total_next = loss_total + TOTAL_W'(1);
        end
        if (push) begin
          tail_next = ring_next(tail);
        end
      end
      if (check) begin
        if (start_svc) begin
          delay_total_next = delay_total + wait_time;
          next_check_next  = next_check + TOTAL_W'(slen);
        end else begin
          idle_total_next = idle_total + TOTAL_W'(1);
          next_check_next = next_check + TOTAL_W'(1);
        end
      end
      remaining_next = counting ? rem_loaded - SERVICE_W'(1) : rem_loaded;
      if (pop) begin
        sojourn_total_next = sojourn_total + wait_time;
        head_next          = ring_next(head);
      end
      count_next = count_pushed - CW'(pop);
      // The new head is the stored entry after the old one, or this tick's packet.
      if (pop) begin
        head_ts_next = (count >= CW'(2)) ? next_entry : t;
      end else if (count == '0) begin
        head_ts_next = t;
      end
      occupancy_total_next = occupancy_total + TOTAL_W'(count_next);
    end else if (first_wr && (tick_count == '0)) begin
      next_arrival_next = TOTAL_W'(first_arrival);
    end
  end

  assign mem_wr_en   = item_valid && push;
  assign mem_wr_addr = tail;
  assign mem_wr_data = t;
  assign mem_rd_addr = ring_next(head_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count      <= '0;
      next_arrival    <= TOTAL_W'(FIRST_RESET);
      next_check      <= TOTAL_W'(1);
      remaining       <= '0;
      head            <= '0;
      tail            <= '0;
      count           <= '0;
      arrival_total   <= '0;
      loss_total      <= '0;
      idle_total      <= '0;
      delay_total     <= '0;
      sojourn_total   <= '0;
      occupancy_total <= '0;
      done            <= 1'b0;
    end else begin
      tick_count      <= tick_count_next;
      next_arrival    <= next_arrival_next;
      next_check      <= next_check_next;
      remaining       <= remaining_next;
      head            <= head_next;
      tail            <= tail_next;
      count           <= count_next;
      arrival_total   <= arrival_total_next;
      loss_total      <= loss_total_next;
      idle_total      <= idle_total_next;
      delay_total     <= delay_total_next;
      sojourn_total   <= sojourn_total_next;
      occupancy_total <= occupancy_total_next;
      done            <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    head_ts <= head_ts_next;
    if (item_valid) begin
      final_flag <= item.last;
    end
  end

  assign queue_occupancy = OCC_W'(count);
  assign packets_arrived = arrival_total;
  assign packets_lost    = loss_total;
  assign idle_checks     = idle_total;
  assign queue_delay_sum = delay_total;
  assign sojourn_sum     = sojourn_total;
  assign occupancy_sum   = occupancy_total;

  // A packet in service keeps the queue non-empty until it departs.
  a_service_has_packet: assert property (@(posedge clk) disable iff (rst)
    (remaining != '0) |-> (count != '0))
    else $error("service running on an empty queue");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    CMPW'(count) <= CMPW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_ring_consistent: assert property (@(posedge clk) disable iff (rst)
    (count != '0) && (count != CW'(QUEUE_DEPTH)) |-> (head != tail))
    else $error("head and tail pointers disagree with count");

  a_one_result_per_tick: assert property (@(posedge clk) disable iff (rst)
    item_valid |=> done && (tick_count == $past(tick_count) + TOTAL_W'(1)))
    else $error("tick did not produce exactly one result");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !item_valid |=> $stable(count) && $stable(occupancy_total))
    else $error("state moved without a tick");

endmodule

[src/tick_driven_md1k_queue_model.sv]
// Tick-driven M/D/1/K queue statistics engine.
//
// Each beat on the command channel is one simulation tick: raise start with
// uniform_sample and last_tick; the beat is taken at a clock edge where start
// is high and busy is low. busy is high only while rst is asserted, so a new
// tick can be issued every cycle.
//
// Every tick yields exactly one result beat. done goes high for one cycle at
// the edge after the one that took the tick, and the beat is taken at the next
// edge, with the queue occupancy, the running 64-bit totals and final_flag.
// Results are not held: the receiver must take them in the cycle done is high.
// Throughput is one tick per cycle; the arrival gap multiply sits in the input
// register stage and the whole queue update runs in the following cycle.
//
// Configuration is written through cfg_wr_en/cfg_index/cfg_data with no
// wait; write it only while no tick is in flight, which is not enforced.
// Writing first_arrival before the first tick also sets the first arrival
// time. Reset (synchronous, high) restores the register defaults and clears
// all counters and the queue; the timestamp memory needs no clearing, since
// entries are read only after they have been written.
module tick_driven_md1k_queue_model
  import mdq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [SAMPLE_W-1:0]    uniform_sample,
  input  logic                   last_tick,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   done,
  output logic [OCC_W-1:0]       queue_occupancy,
  output logic [TOTAL_W-1:0]     packets_arrived,
  output logic [TOTAL_W-1:0]     packets_lost,
  output logic [TOTAL_W-1:0]     idle_checks,
  output logic [TOTAL_W-1:0]     queue_delay_sum,
  output logic [TOTAL_W-1:0]     sojourn_sum,
  output logic [TOTAL_W-1:0]     occupancy_sum,
  output logic                   final_flag
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic [SPAN_W-1:0]    interarrival_span;
  logic [SERVICE_W-1:0] service_ticks;
  logic [LIMIT_W-1:0]   queue_limit;
  logic                 bounded_mode;
  logic                 first_wr;

  logic                 accept;
  logic                 item_valid;
  tick_item_t           item;

  logic                 mem_wr_en;
  logic [AW-1:0]        mem_wr_addr;
  logic [TOTAL_W-1:0]   mem_wr_data;
  logic [AW-1:0]        mem_rd_addr;
  logic [TOTAL_W-1:0]   next_entry;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      interarrival_span <= SPAN_RESET;
      service_ticks     <= SERVICE_RESET;
      queue_limit       <= LIMIT_RESET;
      bounded_mode      <= BOUNDED_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SPAN:    interarrival_span <= cfg_data[SPAN_W-1:0];
        CFG_SERVICE: service_ticks     <= cfg_data[SERVICE_W-1:0];
        CFG_LIMIT:   queue_limit       <= cfg_data[LIMIT_W-1:0];
        CFG_BOUNDED: bounded_mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // first_arrival only seeds the arrival schedule, so the core loads it
  // straight from the write data.
  assign first_wr = cfg_wr_en && (cfg_index == CFG_FIRST);

  mdq_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .sample     (uniform_sample),
    .last       (last_tick),
    .span       (interarrival_span),
    .item_valid (item_valid),
    .item       (item)
  );

  mdq_ts_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ts_mem (
    .clk      (clk),
    .wr_en    (mem_wr_en),
    .wr_addr  (mem_wr_addr),
    .wr_data  (mem_wr_data),
    .rd_addr  (mem_rd_addr),
    .rd_value (next_entry)
  );

  mdq_core #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item            (item),
    .service_ticks   (service_ticks),
    .queue_limit     (queue_limit),
    .bounded_mode    (bounded_mode),
    .first_arrival   (cfg_data[FIRST_W-1:0]),
    .first_wr        (first_wr),
    .mem_wr_en       (mem_wr_en),
    .mem_wr_addr     (mem_wr_addr),
    .mem_wr_data     (mem_wr_data),
    .mem_rd_addr     (mem_rd_addr),
    .next_entry      (next_entry),
    .done            (done),
    .queue_occupancy (queue_occupancy),
    .packets_arrived (packets_arrived),
    .packets_lost    (packets_lost),
    .idle_checks     (idle_checks),
    .queue_delay_sum (queue_delay_sum),
    .sojourn_sum     (sojourn_sum),
    .occupancy_sum   (occupancy_sum),
    .final_flag      (final_flag)
  );

endmodule

[bench/tick_driven_md1k_queue_model_test.sv]
module tick_driven_md1k_queue_model_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mdq_pkg::*;

  localparam int DEPTH = DEFAULT_QUEUE_DEPTH;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [SAMPLE_W-1:0] u;
    logic                fin;
  } tick_req_t;

  typedef struct {
    logic [OCC_W-1:0]   occ;
    logic [TOTAL_W-1:0] arrived;
    logic [TOTAL_W-1:0] lost;
    logic [TOTAL_W-1:0] idle;
    logic [TOTAL_W-1:0] delay;
    logic [TOTAL_W-1:0] sojourn;
    logic [TOTAL_W-1:0] occ_sum;
    logic               fin;
  } tick_stats_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic [SAMPLE_W-1:0]    uniform_sample = '0;
  logic                   last_tick = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_SPAN;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   done;
  logic [OCC_W-1:0]       queue_occupancy;
  logic [TOTAL_W-1:0]     packets_arrived;
  logic [TOTAL_W-1:0]     packets_lost;
  logic [TOTAL_W-1:0]     idle_checks;
  logic [TOTAL_W-1:0]     queue_delay_sum;
  logic [TOTAL_W-1:0]     sojourn_sum;
  logic [TOTAL_W-1:0]     occupancy_sum;
  logic                   final_flag;

  tick_req_t   ticks_to_send[$];
  tick_stats_t stats_due[$];
  tick_req_t   next_req;
  tick_stats_t want;
  int          gap_left = 0;
  bit          allow_gaps = 1'b1;
  int          mismatches = 0;
  int          results_seen = 0;

  // Shadow of the queue model: registers, counters and timestamp store.
  logic [SPAN_W-1:0]    reg_span = SPAN_RESET;
  logic [SERVICE_W-1:0] reg_service = SERVICE_RESET;
  logic [LIMIT_W-1:0]   reg_limit = LIMIT_RESET;
  logic                 reg_bounded = BOUNDED_RESET;
  logic [FIRST_W-1:0]   reg_first = FIRST_RESET;
  logic [TOTAL_W-1:0]   tick_no = '0;
  logic [TOTAL_W-1:0]   arrival_due = TOTAL_W'(FIRST_RESET);
  logic [TOTAL_W-1:0]   check_due = TOTAL_W'(1);
  logic [SERVICE_W-1:0] service_left = '0;
  logic [TOTAL_W-1:0]   stamp_mem[DEPTH];
  int                   head_ptr = 0;
  int                   tail_ptr = 0;
  logic [OCC_W-1:0]     held = '0;
  logic [TOTAL_W-1:0]   arrived_n = '0;
  logic [TOTAL_W-1:0]   lost_n = '0;
  logic [TOTAL_W-1:0]   idle_n = '0;
  logic [TOTAL_W-1:0]   delay_n = '0;
  logic [TOTAL_W-1:0]   sojourn_n = '0;
  logic [TOTAL_W-1:0]   occ_n = '0;

  tick_driven_md1k_queue_model u_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .uniform_sample  (uniform_sample),
    .last_tick       (last_tick),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .done            (done),
    .queue_occupancy (queue_occupancy),
    .packets_arrived (packets_arrived),
    .packets_lost    (packets_lost),
    .idle_checks     (idle_checks),
    .queue_delay_sum (queue_delay_sum),
    .sojourn_sum     (sojourn_sum),
    .occupancy_sum   (occupancy_sum),
    .final_flag      (final_flag)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int ring_step(input int idx);
    return (idx + 1 >= DEPTH) ? 0 : idx + 1;
  endfunction

  function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_SPAN:    reg_span = data[SPAN_W-1:0];
      CFG_SERVICE: reg_service = data[SERVICE_W-1:0];
      CFG_LIMIT:   reg_limit = data[LIMIT_W-1:0];
      CFG_BOUNDED: reg_bounded = data[0];
      CFG_FIRST: begin
        reg_first = data[FIRST_W-1:0];
        // Only a write before the first tick moves the first arrival.
        if (tick_no == '0)
          arrival_due = TOTAL_W'(reg_first);
      end
      default: ;
    endcase
  endfunction

  function automatic tick_stats_t step_queue(input logic [SAMPLE_W-1:0] u,
                                             input logic fin);
    logic [SPAN_W+SAMPLE_W-1:0] scaled;
    logic [SERVICE_W-1:0]       slen;
    logic [OCC_W-1:0]           cap;
    tick_stats_t                r;
    slen = (reg_service == '0) ? SERVICE_W'(1) : reg_service;
    tick_no = tick_no + 1;

    if (tick_no == arrival_due) begin
      arrived_n = arrived_n + 1;
      scaled = (SPAN_W+SAMPLE_W)'(reg_span) * (SPAN_W+SAMPLE_W)'(u);
      arrival_due = arrival_due + TOTAL_W'(scaled >> SAMPLE_W) + 1;
      cap = OCC_W'(DEPTH);
      if (reg_bounded && reg_limit < cap)
        cap = reg_limit;
      if (held >= cap) begin
        lost_n = lost_n + 1;
      end else begin
        stamp_mem[tail_ptr] = tick_no;
        tail_ptr = ring_step(tail_ptr);
        held = held + 1;
      end
    end

    if (tick_no == check_due) begin
      if (held == '0) begin
        service_left = '0;
        check_due = check_due + 1;
        idle_n = idle_n + 1;
      end else begin
        delay_n = delay_n + (tick_no - stamp_mem[head_ptr]);
        service_left = slen;
        check_due = check_due + TOTAL_W'(slen);
      end
    end

    if (service_left != '0) begin
      service_left = service_left - 1;
      if (service_left == '0 && held != '0) begin
        sojourn_n = sojourn_n + (tick_no - stamp_mem[head_ptr]);
        head_ptr = ring_step(head_ptr);
        held = held - 1;
      end
    end

    occ_n = occ_n + TOTAL_W'(held);
    r.occ = held;
    r.arrived = arrived_n;
    r.lost = lost_n;
    r.idle = idle_n;
    r.delay = delay_n;
    r.sojourn = sojourn_n;
    r.occ_sum = occ_n;
    r.fin = fin;
    return r;
  endfunction

  task automatic log_mismatch(input string msg);
    if (mismatches < MAX_PRINTED)
      $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [TOTAL_W-1:0] got,
                               input logic [TOTAL_W-1:0] exp_val);
    if (got !== exp_val)
      log_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                             results_seen, name, got, exp_val));
  endtask

  // Driver: one beat per accepted tick, with random bursts of idle cycles.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy)
        stats_due.push_back(step_queue(uniform_sample, last_tick));
      if (start && busy) begin
        // The beat stays on the ports until busy drops.
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (ticks_to_send.size() != 0 && allow_gaps && $urandom_range(0, 5) == 0) begin
        start <= 1'b0;
        gap_left <= $urandom_range(0, 3);
      end else if (ticks_to_send.size() != 0) begin
        next_req = ticks_to_send.pop_front();
        start <= 1'b1;
        uniform_sample <= next_req.u;
        last_tick <= next_req.fin;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: results cannot be held off, so every done beat is checked here.
  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (stats_due.size() == 0) begin
        log_mismatch($sformatf("result %0d arrived with no tick outstanding", results_seen));
      end else begin
        want = stats_due.pop_front();
        compare_field("queue_occupancy", TOTAL_W'(queue_occupancy), TOTAL_W'(want.occ));
        compare_field("packets_arrived", packets_arrived, want.arrived);
        compare_field("packets_lost", packets_lost, want.lost);
        compare_field("idle_checks", idle_checks, want.idle);
        compare_field("queue_delay_sum", queue_delay_sum, want.delay);
        compare_field("sojourn_sum", sojourn_sum, want.sojourn);
        compare_field("occupancy_sum", occupancy_sum, want.occ_sum);
        compare_field("final_flag", TOTAL_W'(final_flag), TOTAL_W'(want.fin));
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    apply_reg(idx, data);
  endtask

  task automatic queue_tick(input logic [SAMPLE_W-1:0] u, input logic fin);
    tick_req_t req;
    req.u = u;
    req.fin = fin;
    ticks_to_send.push_back(req);
  endtask

  // Waits until every tick is sent and answered, then lets the pipe empty.
  task automatic settle(input int extra);
    do @(posedge clk);
    while (ticks_to_send.size() != 0 || start || stats_due.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  initial begin : stimulus
    int n;
    int svc;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Zero span, zero service and a zero limit: every packet is dropped.
    // The first_arrival write lands before any tick, so it moves the first arrival.
    write_reg(CFG_FIRST, 24'd3);
    write_reg(CFG_SPAN, 24'd0);
    write_reg(CFG_SERVICE, 24'd0);
    write_reg(CFG_BOUNDED, 24'd1);
    write_reg(CFG_LIMIT, 24'd0);
    write_reg(CFG_UNUSED, 24'hFFFFFF);
    queue_tick(16'h0000, 1'b0);
    queue_tick(16'hFFFF, 1'b1);
    queue_tick(16'hAAAA, 1'b0);
    queue_tick(16'h5555, 1'b1);
    queue_tick(16'h0001, 1'b0);
    queue_tick(16'h8000, 1'b0);
    settle(3);

    // A limit above the store depth is clipped to the depth.
    write_reg(CFG_LIMIT, 24'd2047);
    write_reg(CFG_SERVICE, 24'd3);
    write_reg(CFG_SPAN, 24'd2);
    queue_tick(16'hFFFF, 1'b0);
    queue_tick(16'h0000, 1'b0);
    queue_tick(16'hFFFF, 1'b0);
    queue_tick(16'h7FFF, 1'b1);
    queue_tick(16'hFFFF, 1'b0);
    queue_tick(16'h0000, 1'b0);
    queue_tick(16'hFFFF, 1'b0);
    queue_tick(16'hC3C3, 1'b0);
    settle(3);

    // Largest span with small samples keeps the gaps short; the late
    // first_arrival write must leave the arrival schedule alone.
    write_reg(CFG_SPAN, 24'hFFFFFF);
    write_reg(CFG_FIRST, 24'hFFFFFF);
    write_reg(CFG_LIMIT, 24'd1);
    write_reg(CFG_SERVICE, 24'd5);
    for (int i = 0; i < 7; i++)
      queue_tick(16'h0000, i[0]);
    queue_tick(16'h0001, 1'b0);
    settle(3);

    for (int ph = 0; ph < 6; ph++) begin
      svc = $urandom_range(1, 12);
      write_reg(CFG_SERVICE, CFG_DATA_W'(svc));
      write_reg(CFG_SPAN, CFG_DATA_W'($urandom_range(0, 4 * svc)));
      write_reg(CFG_BOUNDED, CFG_DATA_W'($urandom_range(0, 1)));
      case ($urandom_range(0, 3))
        0: write_reg(CFG_LIMIT, CFG_DATA_W'($urandom_range(1, 4)));
        1: write_reg(CFG_LIMIT, CFG_DATA_W'($urandom_range(5, 40)));
        2: write_reg(CFG_LIMIT, CFG_DATA_W'(DEPTH));
        default: write_reg(CFG_LIMIT, CFG_DATA_W'($urandom_range(1, 2047)));
      endcase
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_FIRST, CFG_DATA_W'($urandom_range(1, 100)));
      allow_gaps = ($urandom_range(0, 3) != 0);
      n = $urandom_range(50, 70);
      for (int i = 0; i < n; i++)
        queue_tick(SAMPLE_W'($urandom_range(0, 65535)), $urandom_range(0, 15) == 0);
      settle(3);
    end

    // Back-to-back stream, one push and one pop per tick.
    allow_gaps = 1'b0;
    write_reg(CFG_SPAN, 24'd0);
    write_reg(CFG_SERVICE, 24'd1);
    write_reg(CFG_BOUNDED, 24'd0);
    for (int i = 0; i < 150; i++)
      queue_tick(SAMPLE_W'($urandom_range(0, 65535)), $urandom_range(0, 31) == 0);
    settle(3);

    // Longest service: the bounded queue fills to its limit and then drops.
    write_reg(CFG_SERVICE, 24'hFFFFFF);
    write_reg(CFG_BOUNDED, 24'd1);
    write_reg(CFG_LIMIT, 24'd100);
    for (int i = 0; i < 170; i++)
      queue_tick(SAMPLE_W'($urandom_range(0, 65535)), i == 169);
    settle(8);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
